>>> rtl/cshr_pkg.sv
// shared widths, types and side-band record for the circle/segment hit pipeline
package cshr_pkg;

  // coordinate width, all other widths follow from it
  localparam int CW      = 24;
  localparam int RADW    = CW - 1;
  localparam int DW      = CW + 1;
  localparam int AW      = 2 * DW;
  localparam int BW      = 2 * DW + 2;
  localparam int MW      = BW + 4;
  localparam int HW      = MW / 2;
  localparam int PW      = 2 * MW;
  localparam int SW      = BW;
  localparam int QW      = 2 * SW;
  localparam int NW      = BW + 1;
  localparam int QB      = CW + 1;
  localparam int DENW    = AW + 1;
  localparam int RESW    = CW + 3;
  localparam int DIV_LAT = QB + 1;

  typedef logic signed [CW-1:0]   crd_t;
  typedef logic signed [DW-1:0]   dw_t;
  typedef logic signed [BW-1:0]   bw_t;
  typedef logic signed [MW-1:0]   mop_t;
  typedef logic signed [PW-1:0]   prod_t;
  typedef logic signed [NW-1:0]   nw_t;
  typedef logic signed [RESW-1:0] res_t;
  typedef logic [QW-1:0]          rem_t;
  typedef logic [SW-1:0]          root_t;
  typedef logic [DENW-1:0]        den_t;
  typedef logic [PW-1:0]          num_t;

  // data that rides alongside the square root
  typedef struct packed {
    logic [AW-1:0] a;
    bw_t           nb;
    bw_t           dot2;
    dw_t           dx;
    dw_t           dy;
    crd_t          x1;
    crd_t          y1;
    crd_t          vx;
    crd_t          vy;
    logic          ok;
    logic          pos;
  } sq_side_t;

endpackage

>>> rtl/cshr_mul.sv
// two-stage signed multiplier built from four narrow partial products
module cshr_mul (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  cshr_pkg::mop_t       a_i,
  input  cshr_pkg::mop_t       b_i,
  output cshr_pkg::prod_t      p_o
);

  logic signed [cshr_pkg::HW-1:0]   ah, bh;
  logic signed [cshr_pkg::HW:0]     al, bl;
  logic signed [2*cshr_pkg::HW-1:0] hh_q;
  logic signed [2*cshr_pkg::HW:0]   hl_q, lh_q;
  logic signed [2*cshr_pkg::HW+1:0] ll_q;
  cshr_pkg::prod_t                  p_q;

  // split operands into signed high and unsigned low halves
  assign ah = a_i[cshr_pkg::MW-1:cshr_pkg::HW];
  assign bh = b_i[cshr_pkg::MW-1:cshr_pkg::HW];
  assign al = $signed({1'b0, a_i[cshr_pkg::HW-1:0]});
  assign bl = $signed({1'b0, b_i[cshr_pkg::HW-1:0]});

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= ah * bh;
      hl_q <= ah * bl;
      lh_q <= al * bh;
      ll_q <= al * bl;
    end
  end

  // recombine
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (cshr_pkg::prod_t'(hh_q) <<< (2 * cshr_pkg::HW))
           + (cshr_pkg::prod_t'(hl_q) <<< cshr_pkg::HW)
           + (cshr_pkg::prod_t'(lh_q) <<< cshr_pkg::HW)
           + cshr_pkg::prod_t'(ll_q);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/cshr_sqrt.sv
// pipelined integer floor square root, one result bit per stage
module cshr_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  cshr_pkg::rem_t     rad_i,
  input  cshr_pkg::sq_side_t side_i,
  output logic               vld_o,
  output cshr_pkg::root_t    root_o,
  output cshr_pkg::sq_side_t side_o
);

  cshr_pkg::rem_t     rem_q  [cshr_pkg::SW];
  cshr_pkg::root_t    root_q [cshr_pkg::SW];
  cshr_pkg::sq_side_t side_q [cshr_pkg::SW];
  logic               vld_q  [cshr_pkg::SW];

  for (genvar j = 0; j < cshr_pkg::SW; j++) begin : g_stage
    localparam int BIT = cshr_pkg::SW - 1 - j;
    cshr_pkg::rem_t     rem_in, trial;
    cshr_pkg::root_t    root_in;
    cshr_pkg::sq_side_t side_in;
    logic               vld_in, take;

    if (j == 0) begin : g_head
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_body
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    // try setting this root bit: (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
    assign trial = (cshr_pkg::rem_t'(root_in) << (BIT + 1))
                 | (cshr_pkg::rem_t'(1) << (2 * BIT));
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? rem_in - trial : rem_in;
        root_q[j] <= root_in | (cshr_pkg::root_t'(take) << BIT);
        side_q[j] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[cshr_pkg::SW-1];
  assign root_o = root_q[cshr_pkg::SW-1];
  assign side_o = side_q[cshr_pkg::SW-1];

endmodule

>>> rtl/cshr_div.sv
// pipelined bounded-quotient divider, gives trunc((base*den + m) / den)
module cshr_div (
  input  logic           clk_i,
  input  logic           en_i,
  input  cshr_pkg::num_t mag_i,
  input  logic           neg_i,
  input  cshr_pkg::den_t den_i,
  input  cshr_pkg::crd_t base_i,
  output cshr_pkg::res_t res_o
);

  typedef logic [cshr_pkg::QB-1:0] quo_t;

  cshr_pkg::num_t rem_q  [cshr_pkg::QB];
  quo_t           quo_q  [cshr_pkg::QB];
  cshr_pkg::den_t den_q  [cshr_pkg::QB];
  logic           neg_q  [cshr_pkg::QB];
  cshr_pkg::crd_t base_q [cshr_pkg::QB];
  cshr_pkg::res_t res_q;

  for (genvar j = 0; j < cshr_pkg::QB; j++) begin : g_stage
    localparam int BIT = cshr_pkg::QB - 1 - j;
    cshr_pkg::num_t rem_in, shd;
    quo_t           quo_in;
    cshr_pkg::den_t den_in;
    logic           neg_in, take;
    cshr_pkg::crd_t base_in;

    if (j == 0) begin : g_head
      assign rem_in  = mag_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign neg_in  = neg_i;
      assign base_in = base_i;
    end else begin : g_body
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign den_in  = den_q[j-1];
      assign neg_in  = neg_q[j-1];
      assign base_in = base_q[j-1];
    end

    // restoring step against the shifted divisor
    assign shd  = cshr_pkg::num_t'(den_in) << BIT;
    assign take = (rem_in >= shd);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? rem_in - shd : rem_in;
        quo_q[j]  <= quo_in | (quo_t'(take) << BIT);
        den_q[j]  <= den_in;
        neg_q[j]  <= neg_in;
        base_q[j] <= base_in;
      end
    end
  end

  // floor quotient of the signed numerator, add base, round toward zero
  logic           rnz;
  cshr_pkg::res_t qs, fv, tv;

  assign rnz = |rem_q[cshr_pkg::QB-1];
  assign qs  = cshr_pkg::res_t'(quo_q[cshr_pkg::QB-1]);
  assign fv  = neg_q[cshr_pkg::QB-1] ? -(qs + cshr_pkg::res_t'(rnz)) : qs;
  assign tv  = cshr_pkg::res_t'(base_q[cshr_pkg::QB-1]) + fv;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= tv + cshr_pkg::res_t'(tv[cshr_pkg::RESW-1] && rnz);
    end
  end

  assign res_o = res_q;

endmodule

>>> rtl/circle_segment_hit_reflect_top.sv
// circle / segment crossing points and reflected direction, fully pipelined
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  circle, direction, segment
// m_axis    out  m_axis_tvalid/m_axis_tready  hit count, two points, reflection
//
// one transfer per cycle in both directions while the skid register is empty; at 24-bit
// coordinates the pipe depth is set mostly by the 52-stage square root and the 26-stage dividers
// reset clears only the valid bits along the pipe
// a stalled output is caught in a skid register; the whole pipe holds while it is full
module circle_segment_hit_reflect_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_x, center_y, radius, dir_x, dir_y, seg_start_x, seg_start_y,
  // seg_end_x, seg_end_y (lowest bits first)
  input  logic [215:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_count, first_x, first_y, second_x, second_y, refl_x, refl_y
  output logic [151:0] m_axis_tdata
);

  localparam int CW     = cshr_pkg::CW;
  localparam int OFF_CY = CW;
  localparam int OFF_R  = 2 * CW;
  localparam int OFF_VX = 3 * CW - 1;
  localparam int OFF_VY = 4 * CW - 1;
  localparam int OFF_SX = 5 * CW - 1;
  localparam int OFF_SY = 6 * CW - 1;
  localparam int OFF_EX = 7 * CW - 1;
  localparam int OFF_EY = 8 * CW - 1;

  typedef logic signed [2*cshr_pkg::DW-1:0]      sq_t;
  typedef logic signed [CW+cshr_pkg::DW-1:0]     vd_t;
  typedef logic [2*cshr_pkg::RADW-1:0]           rr_t;

  typedef struct packed {
    logic                   k1;
    logic                   k2;
    logic [cshr_pkg::AW-1:0] a;
    cshr_pkg::crd_t         x1;
    cshr_pkg::crd_t         y1;
    cshr_pkg::crd_t         vx;
    cshr_pkg::crd_t         vy;
  } dv_t;

  typedef struct packed {
    logic           k1;
    logic           k2;
    cshr_pkg::crd_t vx;
    cshr_pkg::crd_t vy;
  } fin_t;

  typedef struct packed {
    logic [1:0]     hc;
    cshr_pkg::crd_t fx;
    cshr_pkg::crd_t fy;
    cshr_pkg::crd_t sx;
    cshr_pkg::crd_t sy;
    cshr_pkg::crd_t rx;
    cshr_pkg::crd_t ry;
  } out_t;

  function automatic cshr_pkg::crd_t sat(input cshr_pkg::res_t v);
    logic [cshr_pkg::RESW-CW:0] top;
    top = v[cshr_pkg::RESW-1:CW-1];
    if (top == '0 || top == '1) begin
      return v[CW-1:0];
    end
    return v[cshr_pkg::RESW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic cshr_pkg::num_t mag(input cshr_pkg::prod_t p);
    return p[cshr_pkg::PW-1] ? cshr_pkg::num_t'(-p) : cshr_pkg::num_t'(p);
  endfunction

  logic en, acc;
  logic sk_vld_q, ov_q;

  // pipe advances unless the skid register holds a result
  assign en            = !sk_vld_q;
  assign acc           = s_axis_tvalid && en;
  assign s_axis_tready = en;

  // input fields
  cshr_pkg::crd_t          in_cx, in_cy, in_vx, in_vy, in_sx, in_sy, in_ex, in_ey;
  logic [cshr_pkg::RADW-1:0] in_r;

  assign in_cx = s_axis_tdata[0 +: CW];
  assign in_cy = s_axis_tdata[OFF_CY +: CW];
  assign in_r  = s_axis_tdata[OFF_R +: cshr_pkg::RADW];
  assign in_vx = s_axis_tdata[OFF_VX +: CW];
  assign in_vy = s_axis_tdata[OFF_VY +: CW];
  assign in_sx = s_axis_tdata[OFF_SX +: CW];
  assign in_sy = s_axis_tdata[OFF_SY +: CW];
  assign in_ex = s_axis_tdata[OFF_EX +: CW];
  assign in_ey = s_axis_tdata[OFF_EY +: CW];

  // stage 1: differences
  logic                      v1_q;
  cshr_pkg::dw_t             dx1_q, dy1_q, px1_q, py1_q;
  cshr_pkg::crd_t            x11_q, y11_q, vx1_q, vy1_q;
  logic [cshr_pkg::RADW-1:0] r1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q <= cshr_pkg::dw_t'(in_ex) - cshr_pkg::dw_t'(in_sx);
      dy1_q <= cshr_pkg::dw_t'(in_ey) - cshr_pkg::dw_t'(in_sy);
      px1_q <= cshr_pkg::dw_t'(in_sx) - cshr_pkg::dw_t'(in_cx);
      py1_q <= cshr_pkg::dw_t'(in_sy) - cshr_pkg::dw_t'(in_cy);
      x11_q <= in_sx;
      y11_q <= in_sy;
      vx1_q <= in_vx;
      vy1_q <= in_vy;
      r1_q  <= in_r;
    end
  end

  // stage 2: narrow products
  logic           v2_q;
  sq_t            dxx_q, dyy_q, dxpx_q, dypy_q, pxx_q, pyy_q;
  rr_t            rr_q;
  vd_t            vdx_q, vdy_q;
  cshr_pkg::dw_t  dx2_q, dy2_q;
  cshr_pkg::crd_t x12_q, y12_q, vx2_q, vy2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dxx_q  <= dx1_q * dx1_q;
      dyy_q  <= dy1_q * dy1_q;
      dxpx_q <= dx1_q * px1_q;
      dypy_q <= dy1_q * py1_q;
      pxx_q  <= px1_q * px1_q;
      pyy_q  <= py1_q * py1_q;
      rr_q   <= r1_q * r1_q;
      vdx_q  <= vy1_q * dx1_q;
      vdy_q  <= vx1_q * dy1_q;
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      x12_q  <= x11_q;
      y12_q  <= y11_q;
      vx2_q  <= vx1_q;
      vy2_q  <= vy1_q;
    end
  end

  // stage 3: quadratic coefficients and doubled dot product with the normal
  logic               v3_q;
  cshr_pkg::sq_side_t sd3_q;
  cshr_pkg::bw_t      c3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd3_q.a    <= dxx_q[cshr_pkg::AW-1:0] + dyy_q[cshr_pkg::AW-1:0];
      sd3_q.nb   <= -((cshr_pkg::bw_t'(dxpx_q) + cshr_pkg::bw_t'(dypy_q)) <<< 1);
      sd3_q.dot2 <= (cshr_pkg::bw_t'(vdx_q) - cshr_pkg::bw_t'(vdy_q)) <<< 1;
      sd3_q.dx   <= dx2_q;
      sd3_q.dy   <= dy2_q;
      sd3_q.x1   <= x12_q;
      sd3_q.y1   <= y12_q;
      sd3_q.vx   <= vx2_q;
      sd3_q.vy   <= vy2_q;
      sd3_q.ok   <= 1'b0;
      sd3_q.pos  <= 1'b0;
      c3_q       <= cshr_pkg::bw_t'(pxx_q) + cshr_pkg::bw_t'(pyy_q) - cshr_pkg::bw_t'(rr_q);
    end
  end

  // stages 4-5: B^2 and A*C
  cshr_pkg::prod_t    bb, ac;
  logic               v4_q, v5_q;
  cshr_pkg::sq_side_t sd4_q, sd5_q;

  cshr_mul u_mul_bb (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (cshr_pkg::mop_t'($signed(sd3_q.nb))),
    .b_i   (cshr_pkg::mop_t'($signed(sd3_q.nb))),
    .p_o   (bb)
  );

  cshr_mul u_mul_ac (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (cshr_pkg::mop_t'(sd3_q.a)),
    .b_i   (cshr_pkg::mop_t'(c3_q)),
    .p_o   (ac)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd4_q <= sd3_q;
      sd5_q <= sd4_q;
    end
  end

  // stage 6: discriminant, clamp to zero when there is nothing to solve
  cshr_pkg::prod_t    disc;
  logic               v6_q;
  cshr_pkg::sq_side_t sd6_d, sd6_q;
  cshr_pkg::rem_t     rad6_q;
  logic               ok6;

  assign disc = bb - (ac <<< 2);
  assign ok6  = (sd5_q.a != '0) && !disc[cshr_pkg::PW-1];

  always_comb begin
    sd6_d     = sd5_q;
    sd6_d.ok  = ok6;
    sd6_d.pos = (disc != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd6_q  <= sd6_d;
      rad6_q <= ok6 ? disc[cshr_pkg::QW-1:0] : '0;
    end
  end

  // square root
  logic               v7w;
  cshr_pkg::root_t    root7;
  cshr_pkg::sq_side_t sd7;

  cshr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v6_q),
    .rad_i  (rad6_q),
    .side_i (sd6_q),
    .vld_o  (v7w),
    .root_o (root7),
    .side_o (sd7)
  );

  // stage 7: the two root numerators and their range tests
  cshr_pkg::nw_t  n1, n2, twoa_s;
  logic           v7_q;
  cshr_pkg::nw_t  n1_q, n2_q;
  cshr_pkg::bw_t  dot2_q;
  cshr_pkg::dw_t  dx7_q, dy7_q;
  dv_t            dv7_q;

  assign n1     = cshr_pkg::nw_t'($signed(sd7.nb)) + cshr_pkg::nw_t'(root7);
  assign n2     = cshr_pkg::nw_t'($signed(sd7.nb)) - cshr_pkg::nw_t'(root7);
  assign twoa_s = cshr_pkg::nw_t'({sd7.a, 1'b0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q     <= n1;
      n2_q     <= n2;
      dot2_q   <= sd7.dot2;
      dx7_q    <= sd7.dx;
      dy7_q    <= sd7.dy;
      dv7_q.k1 <= sd7.ok && !n1[cshr_pkg::NW-1] && (n1 <= twoa_s);
      dv7_q.k2 <= sd7.ok && sd7.pos && !n2[cshr_pkg::NW-1] && (n2 <= twoa_s);
      dv7_q.a  <= sd7.a;
      dv7_q.x1 <= sd7.x1;
      dv7_q.y1 <= sd7.y1;
      dv7_q.vx <= sd7.vx;
      dv7_q.vy <= sd7.vy;
    end
  end

  // stages 8-9: numerator products for both points and the reflection
  cshr_pkg::mop_t  ma [6];
  cshr_pkg::mop_t  mb [6];
  cshr_pkg::prod_t mp [6];
  logic            v8_q, v9_q;
  dv_t             dv8_q, dv9_q;

  assign ma[0] = cshr_pkg::mop_t'(n1_q);
  assign mb[0] = cshr_pkg::mop_t'(dx7_q);
  assign ma[1] = cshr_pkg::mop_t'(n1_q);
  assign mb[1] = cshr_pkg::mop_t'(dy7_q);
  assign ma[2] = cshr_pkg::mop_t'(n2_q);
  assign mb[2] = cshr_pkg::mop_t'(dx7_q);
  assign ma[3] = cshr_pkg::mop_t'(n2_q);
  assign mb[3] = cshr_pkg::mop_t'(dy7_q);
  assign ma[4] = cshr_pkg::mop_t'(dot2_q);
  assign mb[4] = cshr_pkg::mop_t'(dy7_q);
  assign ma[5] = cshr_pkg::mop_t'(dot2_q);
  assign mb[5] = cshr_pkg::mop_t'(dx7_q);

  for (genvar k = 0; k < 6; k++) begin : g_mul
    cshr_mul u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (ma[k]),
      .b_i   (mb[k]),
      .p_o   (mp[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv8_q <= dv7_q;
      dv9_q <= dv8_q;
    end
  end

  // stage 10: magnitude and sign of each numerator (the y reflection term is negated)
  logic           v10_q;
  cshr_pkg::num_t mag_q [6];
  logic           neg_q [6];
  dv_t            dv10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 5; k++) begin
        mag_q[k] <= mag(mp[k]);
        neg_q[k] <= mp[k][cshr_pkg::PW-1];
      end
      mag_q[5] <= mag(mp[5]);
      neg_q[5] <= !mp[5][cshr_pkg::PW-1] && (mp[5] != '0);
      dv10_q   <= dv9_q;
    end
  end

  // dividers
  cshr_pkg::den_t den2a, dena;
  cshr_pkg::crd_t dbase [6];
  cshr_pkg::den_t dden  [6];
  cshr_pkg::res_t dres  [6];

  assign den2a    = {dv10_q.a, 1'b0};
  assign dena     = cshr_pkg::den_t'(dv10_q.a);
  assign dbase[0] = dv10_q.x1;
  assign dbase[1] = dv10_q.y1;
  assign dbase[2] = dv10_q.x1;
  assign dbase[3] = dv10_q.y1;
  assign dbase[4] = dv10_q.vx;
  assign dbase[5] = dv10_q.vy;
  assign dden[0]  = den2a;
  assign dden[1]  = den2a;
  assign dden[2]  = den2a;
  assign dden[3]  = den2a;
  assign dden[4]  = dena;
  assign dden[5]  = dena;

  for (genvar k = 0; k < 6; k++) begin : g_div
    cshr_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .mag_i  (mag_q[k]),
      .neg_i  (neg_q[k]),
      .den_i  (dden[k]),
      .base_i (dbase[k]),
      .res_o  (dres[k])
    );
  end

  // control that travels with the dividers
  logic fv_q [cshr_pkg::DIV_LAT];
  fin_t fd_q [cshr_pkg::DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fd_q[0].k1 <= dv10_q.k1;
      fd_q[0].k2 <= dv10_q.k2;
      fd_q[0].vx <= dv10_q.vx;
      fd_q[0].vy <= dv10_q.vy;
      for (int k = 1; k < cshr_pkg::DIV_LAT; k++) begin
        fd_q[k] <= fd_q[k-1];
      end
    end
  end

  // valid bits along the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      for (int k = 0; k < cshr_pkg::DIV_LAT; k++) begin
        fv_q[k] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= acc;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v7w;
      v8_q    <= v7_q;
      v9_q    <= v8_q;
      v10_q   <= v9_q;
      fv_q[0] <= v10_q;
      for (int k = 1; k < cshr_pkg::DIV_LAT; k++) begin
        fv_q[k] <= fv_q[k-1];
      end
    end
  end

  // result assembly: found points fill the first slot, then the second
  fin_t fl;
  out_t fin, o_q, sk_q, sel;

  assign fl = fd_q[cshr_pkg::DIV_LAT-1];

  always_comb begin
    fin    = '0;
    fin.hc = {1'b0, fl.k1} + {1'b0, fl.k2};
    if (fl.k1) begin
      fin.fx = dres[0][CW-1:0];
      fin.fy = dres[1][CW-1:0];
      if (fl.k2) begin
        fin.sx = dres[2][CW-1:0];
        fin.sy = dres[3][CW-1:0];
      end
    end else if (fl.k2) begin
      fin.fx = dres[2][CW-1:0];
      fin.fy = dres[3][CW-1:0];
    end
    if (fl.k1 || fl.k2) begin
      fin.rx = sat(dres[4]);
      fin.ry = sat(dres[5]);
    end else begin
      fin.rx = fl.vx;
      fin.ry = fl.vy;
    end
  end

  // output register and skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q     <= 1'b0;
      sk_vld_q <= 1'b0;
    end else begin
      if (en) begin
        ov_q <= fv_q[cshr_pkg::DIV_LAT-1];
      end
      if (sk_vld_q) begin
        if (m_axis_tready) begin
          sk_vld_q <= 1'b0;
        end
      end else if (ov_q && !m_axis_tready) begin
        sk_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!sk_vld_q && ov_q && !m_axis_tready) begin
      sk_q <= o_q;
    end
    if (en) begin
      o_q <= fin;
    end
  end

  // output transfer
  assign sel           = sk_vld_q ? sk_q : o_q;
  assign m_axis_tvalid = sk_vld_q || ov_q;

  always_comb begin
    m_axis_tdata                    = '0;
    m_axis_tdata[1:0]               = sel.hc;
    m_axis_tdata[2 +: CW]           = sel.fx;
    m_axis_tdata[2 + CW +: CW]      = sel.fy;
    m_axis_tdata[2 + 2 * CW +: CW]  = sel.sx;
    m_axis_tdata[2 + 3 * CW +: CW]  = sel.sy;
    m_axis_tdata[2 + 4 * CW +: CW]  = sel.rx;
    m_axis_tdata[2 + 5 * CW +: CW]  = sel.ry;
  end

endmodule
